// ===== sv/excess_power_hill_climb_tracker_top_assert.svh =====
// Assertion macros shared by the tracker modules.
`ifndef EXCESS_POWER_HILL_CLIMB_TRACKER_TOP_ASSERT_SVH
`define EXCESS_POWER_HILL_CLIMB_TRACKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPHT_ASSERT_SAME(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("Tracker check failed in the same cycle.");

// The consequent must hold in the cycle after the antecedent.
`define EPHT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("Tracker check failed one cycle later.");

`endif

// ===== sv/epht_pkg.sv =====
package epht_pkg;

	localparam int MAX_CH = 4;
	localparam int PWR_W = 20;
	localparam int MASK_W = 4;
	localparam int MEAS_W = 16;
	localparam int BASE_W = 16;
	localparam int TGT_W = 17;
	localparam int CFG_W = 10;
	localparam int CFG_IDX_W = 1;

	// Widest possible sum of the charger readings.
	localparam int SUM_MAX_W = 22;

	// floor(x / 100) = (x * DIV100_MUL) >> DIV100_SH for every x below 2**22.
	localparam int DIV100_MUL_W = 23;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 23'd5368710;
	localparam int DIV100_SH = 29;

	// floor(y / 5) = (y * DIV5_MUL) >> DIV5_SH for every y below 2**18.
	localparam int DIV5_IN_W = 18;
	localparam logic [DIV5_IN_W-1:0] DIV5_MUL = 18'd209716;
	localparam int DIV5_SH = 20;

	localparam logic [TGT_W-1:0] TARGET_MAX = 17'd131071;

	localparam logic [CFG_W-1:0] STEP_SIZE_RST = 10'd30;
	localparam logic [CFG_W-1:0] DEADBAND_RST = 10'd15;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 1'd1;

	typedef enum logic [1:0] {
		DIR_ZERO = 2'd0,
		DIR_PLUS = 2'd1,
		DIR_MINUS = 2'd2
	} dir_t;

	typedef struct packed {
		logic [CFG_W-1:0] step_size;
		logic [CFG_W-1:0] deadband;
	} cfg_t;

endpackage

// ===== sv/excess_power_hill_climb_tracker_top.sv =====
// Perturb-and-observe tracker for the excess inverter target. Each accepted transaction
// carries the charger readings, the valid mask and the base target; it yields exactly one
// result, the new excess target and the measured power in watts, once it has passed the
// pipeline and the output register. One transaction is accepted every cycle unless
// item_stall holds it off: the power sum and the two constant divisions run in a
// three-stage pipeline, and the tracker state is updated in the final stage in the cycle a
// transaction moves into the output register. The output register and the stage valids let
// new transactions enter while a result waits. Only the first CHARGERS readings are
// counted. Registers step_size (index 0) and deadband (index 1) are written through the
// configuration port, which is always ready; they reset to 30 and 15.
module excess_power_hill_climb_tracker_top #(
	parameter int CHARGERS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [epht_pkg::PWR_W-1:0]     charger_power_0,
	input  logic [epht_pkg::PWR_W-1:0]     charger_power_1,
	input  logic [epht_pkg::PWR_W-1:0]     charger_power_2,
	input  logic [epht_pkg::PWR_W-1:0]     charger_power_3,
	input  logic [epht_pkg::MASK_W-1:0]    valid_mask,
	input  logic [epht_pkg::BASE_W-1:0]    inverter_target,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [epht_pkg::TGT_W-1:0]     excess_target,
	output logic [epht_pkg::MEAS_W-1:0]    measured_power,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [epht_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [epht_pkg::CFG_W-1:0]     cfg_data
);

	logic [epht_pkg::MAX_CH-1:0][epht_pkg::PWR_W-1:0] chg_all;
	epht_pkg::cfg_t                                   cfg_q;

	logic                        take_s3;
	logic                        v_s3;
	logic [epht_pkg::MEAS_W-1:0] power_s3;
	logic [epht_pkg::MEAS_W-1:0] frac_s3;
	logic [epht_pkg::BASE_W-1:0] base_s3;

	assign chg_all = {charger_power_3, charger_power_2, charger_power_1, charger_power_0};
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size <= epht_pkg::STEP_SIZE_RST;
			cfg_q.deadband <= epht_pkg::DEADBAND_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				epht_pkg::CFG_STEP_SIZE: begin
					cfg_q.step_size <= cfg_data;
				end
				epht_pkg::CFG_DEADBAND: begin
					cfg_q.deadband <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	epht_power #(
		.CHARGERS(CHARGERS)
	) u_power (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.chg_in     (chg_all[CHARGERS-1:0]),
		.mask_in    (valid_mask[CHARGERS-1:0]),
		.base_in    (inverter_target),
		.take_s3    (take_s3),
		.v_s3       (v_s3),
		.power_s3   (power_s3),
		.frac_s3    (frac_s3),
		.base_s3    (base_s3)
	);

	epht_climb u_climb (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.v_in           (v_s3),
		.power_in       (power_s3),
		.frac_in        (frac_s3),
		.base_in        (base_s3),
		.take           (take_s3),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.excess_target  (excess_target),
		.measured_power (measured_power)
	);

endmodule

// ===== sv/epht_power.sv =====
module epht_power #(
	parameter int CHARGERS = 4
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          item_valid,
	output logic                                          item_stall,
	input  logic [CHARGERS-1:0][epht_pkg::PWR_W-1:0]      chg_in,
	input  logic [CHARGERS-1:0]                           mask_in,
	input  logic [epht_pkg::BASE_W-1:0]                   base_in,
	input  logic                                          take_s3,
	output logic                                          v_s3,
	output logic [epht_pkg::MEAS_W-1:0]                   power_s3,
	output logic [epht_pkg::MEAS_W-1:0]                   frac_s3,
	output logic [epht_pkg::BASE_W-1:0]                   base_s3
);

	localparam int SUM_W = epht_pkg::PWR_W + $clog2(CHARGERS);
	localparam int DIV_IN_W = epht_pkg::SUM_MAX_W;
	localparam int PROD_W = DIV_IN_W + epht_pkg::DIV100_MUL_W;
	localparam int PROD5_W = 2 * epht_pkg::DIV5_IN_W;

	logic                                     v_s1;
	logic [CHARGERS-1:0][epht_pkg::PWR_W-1:0] chg_s1;
	logic [CHARGERS-1:0]                      mask_s1;
	logic [epht_pkg::BASE_W-1:0]              base_s1;

	logic                                     v_s2;
	logic [epht_pkg::MEAS_W-1:0]              power_s2;
	logic [epht_pkg::BASE_W-1:0]              base_s2;

	logic                                     rdy1;
	logic                                     rdy2;
	logic                                     rdy3;
	logic                                     load1;
	logic                                     load2;
	logic                                     load3;

	logic [SUM_W-1:0]                         sum;
	logic [PROD_W-1:0]                        prod;
	logic [epht_pkg::DIV5_IN_W-1:0]           four_p;
	logic [PROD5_W-1:0]                       prod5;

	assign rdy3 = !v_s3 || take_s3;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign item_stall = !rdy1;

	assign load1 = item_valid && rdy1;
	assign load2 = v_s1 && rdy2;
	assign load3 = v_s2 && rdy3;

	always_comb begin
		sum = '0;
		for (int i = 0; i < CHARGERS; i++) begin
			if (mask_s1[i]) begin
				sum = sum + SUM_W'(chg_s1[i]);
			end
		end
	end

	assign prod = PROD_W'(DIV_IN_W'(sum)) * PROD_W'(epht_pkg::DIV100_MUL);

	assign four_p = {power_s2, 2'b00};
	assign prod5 = PROD5_W'(four_p) * PROD5_W'(epht_pkg::DIV5_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= item_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			chg_s1 <= chg_in;
			mask_s1 <= mask_in;
			base_s1 <= base_in;
		end
		if (load2) begin
			power_s2 <= prod[epht_pkg::DIV100_SH +: epht_pkg::MEAS_W];
			base_s2 <= base_s1;
		end
		if (load3) begin
			power_s3 <= power_s2;
			frac_s3 <= prod5[epht_pkg::DIV5_SH +: epht_pkg::MEAS_W];
			base_s3 <= base_s2;
		end
	end

endmodule

// ===== sv/epht_climb.sv =====
`include "excess_power_hill_climb_tracker_top_assert.svh"

module epht_climb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  epht_pkg::cfg_t              cfg,
	input  logic                        v_in,
	input  logic [epht_pkg::MEAS_W-1:0] power_in,
	input  logic [epht_pkg::MEAS_W-1:0] frac_in,
	input  logic [epht_pkg::BASE_W-1:0] base_in,
	output logic                        take,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [epht_pkg::TGT_W-1:0]  excess_target,
	output logic [epht_pkg::MEAS_W-1:0] measured_power
);

	localparam int CW = epht_pkg::TGT_W + 2;
	localparam int DW = epht_pkg::MEAS_W + 2;

	logic                        valid_q;
	logic [epht_pkg::TGT_W-1:0]  excess_q;
	logic [epht_pkg::MEAS_W-1:0] meas_q;

	logic [epht_pkg::MEAS_W-1:0] last_q;
	epht_pkg::dir_t              dir_q;
	logic [epht_pkg::TGT_W-1:0]  tgt_q;
	logic                        primed_q;

	logic [epht_pkg::MEAS_W-1:0] nxt_last;
	epht_pkg::dir_t              nxt_dir;
	epht_pkg::dir_t              step_dir;
	logic [epht_pkg::TGT_W-1:0]  nxt_tgt;

	logic signed [CW-1:0]        t_s;
	logic signed [CW-1:0]        ss_s;
	logic signed [CW-1:0]        b_s;
	logic signed [CW-1:0]        p_s;
	logic signed [CW-1:0]        frac_s;
	logic signed [CW-1:0]        cand;
	logic signed [DW-1:0]        diff;
	logic signed [DW-1:0]        mag;

	assign take = v_in && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign excess_target = excess_q;
	assign measured_power = meas_q;

	assign t_s = $signed(CW'(tgt_q));
	assign ss_s = $signed(CW'(cfg.step_size));
	assign b_s = $signed(CW'(base_in));
	assign p_s = $signed(CW'(power_in));
	assign frac_s = $signed(CW'(frac_in));
	assign diff = $signed(DW'(last_q)) - $signed(DW'(power_in));
	assign mag = (diff < 0) ? -diff : diff;

	always_comb begin
		nxt_last = last_q;
		nxt_dir = dir_q;
		step_dir = epht_pkg::DIR_PLUS;
		cand = t_s;
		if (!primed_q) begin
			nxt_last = power_in;
			nxt_dir = epht_pkg::DIR_PLUS;
			cand = (power_in > base_in) ? b_s + ss_s : b_s;
		end else if (power_in < base_in) begin
			cand = b_s;
			nxt_dir = epht_pkg::DIR_ZERO;
			nxt_last = power_in;
		end else begin
			if (mag < $signed(DW'(cfg.deadband))) begin
				cand = (t_s > p_s) ? frac_s : t_s - ss_s;
				nxt_dir = epht_pkg::DIR_MINUS;
			end else begin
				if (dir_q == epht_pkg::DIR_MINUS) begin
					step_dir = epht_pkg::DIR_MINUS;
				end
				if (diff > 0) begin
					step_dir = (step_dir == epht_pkg::DIR_PLUS) ? epht_pkg::DIR_MINUS :
						epht_pkg::DIR_PLUS;
				end
				cand = (step_dir == epht_pkg::DIR_PLUS) ? t_s + ss_s : t_s - ss_s;
				nxt_dir = step_dir;
				nxt_last = power_in;
			end
			if (cand < b_s) begin
				cand = b_s;
				nxt_dir = epht_pkg::DIR_PLUS;
				nxt_last = power_in;
			end
		end
		if (cand > $signed(CW'(epht_pkg::TARGET_MAX))) begin
			nxt_tgt = epht_pkg::TARGET_MAX;
		end else begin
			nxt_tgt = cand[epht_pkg::TGT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q <= '0;
			dir_q <= epht_pkg::DIR_PLUS;
			tgt_q <= '0;
			primed_q <= 1'b0;
		end else begin
			if (!valid_q || !result_stall) begin
				valid_q <= v_in;
			end
			if (take) begin
				last_q <= nxt_last;
				dir_q <= nxt_dir;
				tgt_q <= nxt_tgt;
				primed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			excess_q <= nxt_tgt;
			meas_q <= power_in;
		end
	end

	`EPHT_ASSERT_SAME(a_out_matches_state, clk, arst_n, valid_q, excess_q == tgt_q)
	`EPHT_ASSERT_NEXT(a_primed_sticks, clk, arst_n, primed_q, primed_q)
	`EPHT_ASSERT_NEXT(a_take_fills, clk, arst_n, take, valid_q && primed_q)
	`EPHT_ASSERT_NEXT(a_below_base_zero, clk, arst_n, take && primed_q && (power_in < base_in), dir_q == epht_pkg::DIR_ZERO)

endmodule

// ===== tb/tb_excess_power_hill_climb_tracker_top.sv =====
`timescale 1ns / 1ps

module tb_excess_power_hill_climb_tracker_top;

	localparam int MAX_CH = epht_pkg::MAX_CH;
	localparam int PWR_W = epht_pkg::PWR_W;
	localparam int MASK_W = epht_pkg::MASK_W;
	localparam int MEAS_W = epht_pkg::MEAS_W;
	localparam int BASE_W = epht_pkg::BASE_W;
	localparam int TGT_W = epht_pkg::TGT_W;
	localparam int CFG_W = epht_pkg::CFG_W;
	localparam int CFG_IDX_W = epht_pkg::CFG_IDX_W;
	localparam int SUM_MAX_W = epht_pkg::SUM_MAX_W;

	typedef struct packed {
		logic [MAX_CH-1:0][PWR_W-1:0] pwr;
		logic [MASK_W-1:0]            mask;
		logic [BASE_W-1:0]            base;
	} tick_t;

	typedef struct packed {
		logic [TGT_W-1:0]  target;
		logic [MEAS_W-1:0] meas;
	} tracker_out_t;

	typedef struct {
		tick_t        t;
		bit           has_want;
		tracker_out_t want;
	} tick_row_t;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic [PWR_W-1:0]     charger_power_0 = '0;
	logic [PWR_W-1:0]     charger_power_1 = '0;
	logic [PWR_W-1:0]     charger_power_2 = '0;
	logic [PWR_W-1:0]     charger_power_3 = '0;
	logic [MASK_W-1:0]    valid_mask = '0;
	logic [BASE_W-1:0]    inverter_target = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [TGT_W-1:0]     excess_target;
	logic [MEAS_W-1:0]    measured_power;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = epht_pkg::CFG_STEP_SIZE;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Tracker state as the block should hold it.
	logic [CFG_W-1:0]  reg_step = epht_pkg::STEP_SIZE_RST;
	logic [CFG_W-1:0]  reg_deadband = epht_pkg::DEADBAND_RST;
	logic [MEAS_W-1:0] trk_last = '0;
	epht_pkg::dir_t    trk_dir = epht_pkg::DIR_PLUS;
	logic [TGT_W-1:0]  trk_target = '0;
	bit                trk_primed = 1'b0;

	tracker_out_t due_outputs[$];
	tick_row_t    directed_rows[$];
	bit           row_has_want = 1'b0;
	tracker_out_t row_want = '0;
	int           mismatch_count = 0;

	int send_pct = 0;
	int recv_pct = 0;
	bit hold_phase = 1'b0;
	bit hold_done = 1'b0;
	int hold_cnt = 0;
	int walk_level = 1000;
	int gen_db = int'(epht_pkg::DEADBAND_RST);

	excess_power_hill_climb_tracker_top #(
		.CHARGERS(4)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.charger_power_0(charger_power_0),
		.charger_power_1(charger_power_1),
		.charger_power_2(charger_power_2),
		.charger_power_3(charger_power_3),
		.valid_mask(valid_mask),
		.inverter_target(inverter_target),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.excess_target(excess_target),
		.measured_power(measured_power),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic tracker_out_t track_tick(input tick_t t);
		logic [SUM_MAX_W-1:0] sum;
		longint pw;
		longint base;
		longint step;
		longint db;
		longint tgt;
		longint diff;
		longint mag;
		tracker_out_t r;
		int i;
		sum = '0;
		for (i = 0; i < MAX_CH; i++) begin
			if (t.mask[i]) begin
				sum = sum + SUM_MAX_W'(t.pwr[i]);
			end
		end
		pw = longint'(sum) / 100;
		base = longint'(t.base);
		step = longint'(reg_step);
		db = longint'(reg_deadband);
		tgt = longint'(trk_target);
		if (!trk_primed) begin
			trk_primed = 1'b1;
			trk_last = pw[MEAS_W-1:0];
			trk_dir = epht_pkg::DIR_PLUS;
			tgt = (pw > base) ? base + step : base;
		end else if (pw < base) begin
			tgt = base;
			trk_dir = epht_pkg::DIR_ZERO;
			trk_last = pw[MEAS_W-1:0];
		end else begin
			diff = longint'(trk_last) - pw;
			mag = (diff < 0) ? -diff : diff;
			if (mag < db) begin
				tgt = (tgt > pw) ? (pw * 4) / 5 : tgt - step;
				trk_dir = epht_pkg::DIR_MINUS;
			end else begin
				if (trk_dir != epht_pkg::DIR_PLUS && trk_dir != epht_pkg::DIR_MINUS) begin
					trk_dir = epht_pkg::DIR_PLUS;
				end
				if (diff > 0) begin
					trk_dir = (trk_dir == epht_pkg::DIR_PLUS) ? epht_pkg::DIR_MINUS :
						epht_pkg::DIR_PLUS;
				end
				tgt = (trk_dir == epht_pkg::DIR_PLUS) ? tgt + step : tgt - step;
				trk_last = pw[MEAS_W-1:0];
			end
			if (tgt < base) begin
				tgt = base;
				trk_dir = epht_pkg::DIR_PLUS;
				trk_last = pw[MEAS_W-1:0];
			end
		end
		if (tgt < 0) begin
			tgt = 0;
		end else if (tgt > longint'(epht_pkg::TARGET_MAX)) begin
			tgt = longint'(epht_pkg::TARGET_MAX);
		end
		trk_target = tgt[TGT_W-1:0];
		r.target = trk_target;
		r.meas = pw[MEAS_W-1:0];
		return r;
	endfunction

	// Mostly a slowly walking production level with the base below it, plus some raw noise.
	function automatic tick_t make_tick();
		tick_t t;
		int i;
		int k;
		int left;
		int maxl;
		int unsigned rem;
		int unsigned lo;
		int unsigned hi;
		if ($urandom_range(0, 99) < 15) begin
			for (i = 0; i < MAX_CH; i++) begin
				t.pwr[i] = PWR_W'($urandom);
			end
			t.mask = MASK_W'($urandom);
			t.base = BASE_W'($urandom);
			return t;
		end
		case ($urandom_range(0, 9))
			0: walk_level = $urandom_range(0, 41000);
			1, 2: walk_level = walk_level + $urandom_range(0, 2 * gen_db) - gen_db;
			default: begin
				if ($urandom_range(0, 1)) begin
					walk_level = walk_level + gen_db + $urandom_range(0, 40);
				end else begin
					walk_level = walk_level - gen_db - $urandom_range(0, 40);
				end
			end
		endcase
		if (walk_level < 0) begin
			walk_level = 0;
		end else if (walk_level > 41000) begin
			walk_level = 41000;
		end
		t.mask = MASK_W'($urandom_range(1, 15));
		k = $countones(t.mask);
		maxl = (k * 1048575 - 99) / 100;
		if (walk_level > maxl) begin
			walk_level = maxl;
		end
		rem = walk_level * 100 + $urandom_range(0, 99);
		left = k;
		for (i = 0; i < MAX_CH; i++) begin
			if (t.mask[i]) begin
				left--;
				if (left == 0) begin
					t.pwr[i] = PWR_W'(rem);
				end else begin
					lo = (rem > left * 1048575) ? rem - left * 1048575 : 0;
					hi = (rem < 1048575) ? rem : 1048575;
					t.pwr[i] = PWR_W'($urandom_range(hi, lo));
				end
				rem = rem - t.pwr[i];
			end else begin
				t.pwr[i] = PWR_W'($urandom);
			end
		end
		case ($urandom_range(0, 9))
			0: t.base = BASE_W'(walk_level + $urandom_range(1, 400));
			1: t.base = BASE_W'(walk_level);
			default: t.base = BASE_W'($urandom_range(0, walk_level));
		endcase
		return t;
	endfunction

	task automatic add_row(input logic [PWR_W-1:0] p0, input logic [PWR_W-1:0] p1,
			input logic [PWR_W-1:0] p2, input logic [PWR_W-1:0] p3,
			input logic [MASK_W-1:0] mask, input logic [BASE_W-1:0] base,
			input bit has_want, input logic [TGT_W-1:0] tgt, input logic [MEAS_W-1:0] meas);
		tick_row_t row;
		row.t.pwr[0] = p0;
		row.t.pwr[1] = p1;
		row.t.pwr[2] = p2;
		row.t.pwr[3] = p3;
		row.t.mask = mask;
		row.t.base = base;
		row.has_want = has_want;
		row.want.target = tgt;
		row.want.meas = meas;
		directed_rows.push_back(row);
	endtask

	task automatic set_idle(input idle_mode_t mode);
		send_pct = (mode == IDLE_SEND) ? 68 : (mode == IDLE_BOTH) ? 22 : 0;
		recv_pct = (mode == IDLE_RECV) ? 68 : (mode == IDLE_BOTH) ? 22 : 0;
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction is taken.
	task automatic send_tick(input tick_t t, input bit has_want, input tracker_out_t want);
		while ($urandom_range(0, 99) < send_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		charger_power_0 <= t.pwr[0];
		charger_power_1 <= t.pwr[1];
		charger_power_2 <= t.pwr[2];
		charger_power_3 <= t.pwr[3];
		valid_mask <= t.mask;
		inverter_target <= t.base;
		row_has_want <= has_want;
		row_want <= want;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] db);
		cfg_valid <= 1'b1;
		cfg_index <= epht_pkg::CFG_STEP_SIZE;
		cfg_data <= step;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= epht_pkg::CFG_DEADBAND;
		cfg_data <= db;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		gen_db = int'(db);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (due_outputs.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic send_random(input int n);
		repeat (n) begin
			send_tick(make_tick(), 1'b0, '0);
		end
	endtask

	always @(negedge clk) begin : drive_result_stall
		if (hold_cnt != 0) begin
			hold_cnt = hold_cnt - 1;
		end else if (hold_phase && !hold_done) begin
			hold_cnt = 80;
			hold_done = 1'b1;
		end
		result_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < recv_pct);
	end

	always @(posedge clk) begin : watch_ports
		tick_t seen;
		tracker_out_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == epht_pkg::CFG_STEP_SIZE) begin
					reg_step = cfg_data;
				end else if (cfg_index == epht_pkg::CFG_DEADBAND) begin
					reg_deadband = cfg_data;
				end
			end
			if (item_valid && !item_stall) begin
				seen.pwr[0] = charger_power_0;
				seen.pwr[1] = charger_power_1;
				seen.pwr[2] = charger_power_2;
				seen.pwr[3] = charger_power_3;
				seen.mask = valid_mask;
				seen.base = inverter_target;
				want = track_tick(seen);
				due_outputs.push_back(row_has_want ? row_want : want);
			end
			if (result_valid && !result_stall) begin
				if (due_outputs.size() == 0) begin
					$error("result transaction with no expected output pending");
					mismatch_count++;
				end else begin
					want = due_outputs.pop_front();
					if (excess_target !== want.target) begin
						$error("excess_target: expected %0d, actual %0d", want.target, excess_target);
						mismatch_count++;
					end
					if (measured_power !== want.meas) begin
						$error("measured_power: expected %0d, actual %0d", want.meas, measured_power);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		tick_t climb;
		add_row(20'd100000, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd500, 1'b1, 17'd530, 16'd1000);
		add_row(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 4'b1111, 16'd0, 1'b1, 17'd560, 16'd41943);
		add_row(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 4'b1111, 16'd0, 1'b1, 17'd530, 16'd41943);
		add_row(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 4'b0000, 16'd0, 1'b1, 17'd560, 16'd0);
		add_row(20'd0, 20'd0, 20'd0, 20'd0, 4'b0000, 16'hFFFF, 1'b1, 17'd65535, 16'd0);
		add_row(20'd0, 20'd0, 20'd0, 20'd0, 4'b0000, 16'd0, 1'b1, 17'd0, 16'd0);
		add_row(20'd99, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd0, 1'b1, 17'd0, 16'd0);
		add_row(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 4'b0101, 16'd0, 1'b1, 17'd30, 16'd20971);
		add_row(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 4'b1010, 16'd0, 1'b1, 17'd0, 16'd20971);
		add_row(20'd100000, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd0, 1'b0, '0, '0);
		add_row(20'd101000, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd1000, 1'b0, '0, '0);
		add_row(20'd99900, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd0, 1'b0, '0, '0);
		add_row(20'd110000, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd0, 1'b0, '0, '0);
		add_row(20'd105000, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd0, 1'b0, '0, '0);
		add_row(20'd106500, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd0, 1'b0, '0, '0);
		add_row(20'd107900, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd0, 1'b0, '0, '0);
		add_row(20'd106500, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd1065, 1'b0, '0, '0);
		add_row(20'd106400, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd1065, 1'b0, '0, '0);
		add_row(20'd120000, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd0, 1'b0, '0, '0);
		add_row(20'd50000, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd600, 1'b0, '0, '0);
		add_row(20'd40000, 20'd0, 20'd0, 20'd0, 4'b0001, 16'd0, 1'b0, '0, '0);
		add_row(20'd25, 20'd25, 20'd25, 20'd25, 4'b1111, 16'd0, 1'b0, '0, '0);
		add_row(20'h5A5A5, 20'hA5A5A, 20'h0F0F0, 20'hF0F0F, 4'b1100, 16'hAAAA, 1'b0, '0, '0);
		add_row(20'hA5A5A, 20'h5A5A5, 20'hF0F0F, 20'h0F0F0, 4'b0011, 16'h5555, 1'b0, '0, '0);

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idle(IDLE_NONE);
		foreach (directed_rows[i]) begin
			send_tick(directed_rows[i].t, directed_rows[i].has_want, directed_rows[i].want);
		end
		drain();

		// Zero deadband and the largest step climb the target into saturation,
		// while the receiver holds off long enough to back up the pipeline.
		set_regs(10'd1023, 10'd0);
		set_idle(IDLE_RECV);
		hold_phase = 1'b1;
		climb = make_tick();
		climb.base = '0;
		repeat (180) begin
			send_tick(climb, 1'b0, '0);
		end
		hold_phase = 1'b0;
		drain();

		set_regs(10'd1, 10'd1023);
		set_idle(IDLE_SEND);
		send_random(120);
		drain();

		set_regs(10'd0, 10'd0);
		set_idle(IDLE_BOTH);
		send_random(100);
		drain();

		set_regs(CFG_W'($urandom_range(1, 300)), CFG_W'($urandom_range(0, 200)));
		set_idle(IDLE_RECV);
		send_random(120);
		drain();

		set_regs(CFG_W'($urandom_range(1, 1023)), CFG_W'($urandom_range(0, 1023)));
		set_idle(IDLE_NONE);
		send_random(100);
		drain();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
